@@ sv/cic_pkg.sv @@
// cic_pkg: shared types and constants of the cloud-in-cell mass deposit block
// word layouts, status codes, register indexes and reset values
// no dependencies
package cic_pkg;

	localparam int POS_W   = 32;
	localparam int MASS_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int CELL_W  = 15;
	localparam int ACC_W   = 48;
	localparam int IDX_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [FRAC_W:0]  W_ONE   = 17'h10000;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_OOB  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SCALE = 2'd2;

	localparam logic [5:0]       TYPE_MASK_RST  = 6'd63;
	localparam logic [POS_W-1:0] BOX_LENGTH_RST = 32'd2097152;
	localparam logic [POS_W-1:0] GRID_SCALE_RST = 32'd65536;

	typedef struct packed {
		logic [5:0]       type_mask;
		logic [POS_W-1:0] box_length;
		logic [POS_W-1:0] grid_scale;
	} cfg_t;

	typedef struct packed {
		logic              req_type;
		logic [2:0]        part_type;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_z;
		logic [MASS_W-1:0] mass;
		logic [CELL_W-1:0] cell_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ACC_W-1:0] cell_mass;
		logic [ACC_W-1:0] total_mass;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_READ = 2'd0,
		OP_SKIP = 2'd1,
		OP_OOB  = 2'd2,
		OP_DEP  = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t                     kind;
		logic [MASS_W-1:0]            mass;
		logic [2:0][IDX_W-1:0]        lo;
		logic [2:0][FRAC_W-1:0]       frac;
		logic [CELL_W-1:0]            cell_idx;
	} op_t;

endpackage

@@ sv/cic_stream_if.sv @@
// cic_stream_if: valid/ready channel carrying one word of type T
// no dependencies
interface cic_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/cloud_in_cell_mass_deposit_unit.sv @@
// cloud_in_cell_mass_deposit_unit: top level, config registers, front, op queue,
// back and result queue
// depends on cic_pkg, cic_stream_if, cic_queue, cic_front, cic_back, cic_ram
//
//   channel    dir  handshake            word
//   particle   in   valid/ready          in_word_t (request: deposit or cell read)
//   result     out  valid/ready          out_word_t (status, cell mass, total)
//   cfg        in   cfg_wr_en            cfg_index, cfg_data
//
// deposit: the back walks eight corners per word, each a grid read-modify-write; the
// front runs three multiplies on one shared 32x32 multiplier, four remainder steps
// and a hand-off. reads and rejected words skip those steps and take one corner slot.
// after front hand-off each corner passes back stages s1, s2 and s3; the result leaves with the last.
// after reset the grid is cleared, all GRID_SIDE**3 cells (32768 by default), particle
// ready low meanwhile. a stalled result side fills the two queues, then particle stalls.
module cloud_in_cell_mass_deposit_unit
	import cic_pkg::*;
#(
	parameter int GRID_SIDE = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cic_stream_if.sink            particle,
	cic_stream_if.source          result
);
	cfg_t cfg_q;
	logic clearing;
	logic res_taken;

	cic_stream_if #(.T(op_t))       cmd_ch ();
	cic_stream_if #(.T(op_t))       op_ch ();
	cic_stream_if #(.T(out_word_t)) res_ch ();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.type_mask  <= TYPE_MASK_RST;
			cfg_q.box_length <= BOX_LENGTH_RST;
			cfg_q.grid_scale <= GRID_SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TYPE_MASK:  cfg_q.type_mask  <= cfg_data[5:0];
				REG_BOX_LENGTH: cfg_q.box_length <= cfg_data;
				REG_GRID_SCALE: cfg_q.grid_scale <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cic_front #(
		.GRID_SIDE(GRID_SIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.req      (particle),
		.cmd      (cmd_ch)
	);

	cic_queue #(
		.T     (op_t),
		.DEPTH (2)
	) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_ch),
		.rd     (op_ch)
	);

	assign res_taken = result.valid && result.ready;

	cic_back #(
		.GRID_SIDE(GRID_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_ch),
		.res       (res_ch),
		.res_taken (res_taken),
		.clearing  (clearing)
	);

	cic_queue #(
		.T     (out_word_t),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_ch),
		.rd     (result)
	);

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> res_ch.ready)
		else $error("result word produced with no room in result queue");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing |=> !clearing)
		else $error("grid clear restarted");

	a_no_op_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(op_ch.valid && op_ch.ready) |-> !clearing)
		else $error("op dispatched during grid clear");
endmodule

@@ sv/cic_ram.sv @@
// cic_ram: generic single write port, single read port memory, registered read
// no dependencies
module cic_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ sv/cic_queue.sv @@
// cic_queue: short fifo of words between two stream channels
// depends on cic_pkg and cic_stream_if
module cic_queue
	import cic_pkg::*;
#(
	parameter type T = op_t,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	cic_stream_if.sink   wr,
	cic_stream_if.source rd
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T               slot_q [DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           push, pop;

	assign wr.ready = (cnt_q != CW'(DEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = slot_q[rp_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr.data;
		end
	end
endmodule

@@ sv/cic_front.sv @@
// cic_front: accepts requests, classifies them, splits positions into cell and fraction
// depends on cic_pkg and cic_stream_if
module cic_front
	import cic_pkg::*;
#(
	parameter int GRID_SIDE = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic clearing,
	cic_stream_if.sink   req,
	cic_stream_if.source cmd
);
	localparam int IW = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
	localparam logic [IW:0] SIDE_W = (IW + 1)'(GRID_SIDE);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_MOD  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t               state_q, state_d;
	logic [1:0]            axis_q;
	logic [1:0]            step_q;
	logic [2:0][POS_W-1:0] pos_q;
	logic [2:0][POS_W-1:0] int_q;
	logic [2:0][IW-1:0]    rem_q, rem_d;
	op_t                   op_q;

	in_word_t              w;
	op_kind_t              kind_c;
	logic                  accept;
	logic                  type_ok, in_box;
	logic [7:0]            mask_ext;
	logic [63:0]           prod;

	assign w        = req.data;
	assign mask_ext = {2'b00, cfg.type_mask};
	assign type_ok  = mask_ext[w.part_type];
	assign in_box   = (w.pos_x <= cfg.box_length) && (w.pos_y <= cfg.box_length)
		&& (w.pos_z <= cfg.box_length);

	always_comb begin
		if (w.req_type) begin
			kind_c = OP_READ;
		end else if (!type_ok) begin
			kind_c = OP_SKIP;
		end else if (!in_box) begin
			kind_c = OP_OOB;
		end else begin
			kind_c = OP_DEP;
		end
	end

	assign req.ready = !clearing
		&& ((state_q == F_IDLE) || ((state_q == F_PUSH) && cmd.ready));
	assign accept    = req.valid && req.ready;
	assign cmd.valid = (state_q == F_PUSH);
	assign cmd.data  = op_q;

	assign prod = 64'(pos_q[axis_q]) * 64'(cfg.grid_scale);

	// remainder of the integer part by the grid side, one byte per step
	always_comb begin
		logic [IW-1:0] r;
		logic [IW:0]   r2;
		logic [7:0]    byte_v;
		logic [1:0]    sel;
		sel = 2'd3 - step_q;
		for (int a = 0; a < 3; a++) begin
			r = rem_q[a];
			byte_v = int_q[a][{sel, 3'b000} +: 8];
			for (int b = 7; b >= 0; b--) begin
				r2 = {r, byte_v[b]};
				if (r2 >= SIDE_W) begin
					r2 = r2 - SIDE_W;
				end
				r = r2[IW-1:0];
			end
			rem_d[a] = r;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (kind_c == OP_DEP) ? F_MUL : F_PUSH;
				end
			end
			F_MUL: begin
				if (axis_q == 2'd2) begin
					state_d = F_MOD;
				end
			end
			F_MOD: begin
				if (step_q == 2'd3) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (accept) begin
					state_d = (kind_c == OP_DEP) ? F_MUL : F_PUSH;
				end else if (cmd.ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			axis_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_MUL) begin
				axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
			end
			if (state_q == F_MOD) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.kind     <= kind_c;
			op_q.mass     <= w.mass;
			op_q.cell_idx <= w.cell_index;
			pos_q         <= {w.pos_z, w.pos_y, w.pos_x};
			rem_q         <= '0;
		end
		if (state_q == F_MUL) begin
			int_q[axis_q]     <= prod[63:32];
			op_q.frac[axis_q] <= prod[31:16];
		end
		if (state_q == F_MOD) begin
			rem_q <= rem_d;
			for (int a = 0; a < 3; a++) begin
				op_q.lo[a] <= IDX_W'(rem_d[a]);
			end
		end
	end
endmodule

@@ sv/cic_back.sv @@
// cic_back: walks the eight corners of each deposit through weight multiplies
// and a read-modify-write of the grid memory; serves cell reads and the total
// depends on cic_pkg, cic_stream_if and cic_ram
module cic_back
	import cic_pkg::*;
#(
	parameter int GRID_SIDE = 32
) (
	input  logic clk,
	input  logic arst_n,
	cic_stream_if.sink   op,
	cic_stream_if.source res,
	input  logic res_taken,
	output logic clearing
);
	localparam int NCELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int AW = $clog2(NCELLS);
	localparam logic [31:0]    NCELLS32 = 32'(NCELLS);
	localparam logic [31:0]    SIDE32   = 32'(GRID_SIDE);
	localparam logic [31:0]    SQ32     = 32'(GRID_SIDE * GRID_SIDE);
	localparam logic [IDX_W:0] SIDE_X   = (IDX_W + 1)'(GRID_SIDE);

	// dispatch
	logic       busy_q;
	op_t        cur_q;
	logic [2:0] corner_q;
	logic [1:0] pend_q;
	logic       issue_last, pop;

	// grid clear
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	// corner decode
	logic [2:0][IDX_W-1:0] idx_c;
	logic [2:0][FRAC_W:0]  wgt_c;
	logic [AW-1:0]         addr_c;
	logic                  rd_ok_c;
	logic [32:0]           wxy_c;

	// pipeline
	logic              v_s1, v_s2, v_s3;
	logic              last_s1, last_s2, last_s3;
	op_kind_t          kind_s1, kind_s2, kind_s3;
	logic [AW-1:0]     addr_s1, addr_s2, addr_s3;
	logic              rd_ok_s1, rd_ok_s2, rd_ok_s3;
	logic [MASS_W-1:0] mass_s1, mass_s2, mass_s3;
	logic [32:0]       wxy_s1;
	logic [FRAC_W:0]   wz_s1;
	logic [32:0]       w_s2;
	logic [ACC_W-1:0]  add_s3;
	logic [49:0]       prod_w;
	logic [64:0]       prod_m;

	// memory and forwarding
	logic             we, re;
	logic [AW-1:0]    waddr;
	logic [ACC_W-1:0] wdata, rdata, cur, cell_new;
	logic [ACC_W:0]   sum_cell, sum_tot;
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [ACC_W-1:0] fwd_data_q;
	logic [ACC_W-1:0] mass_sum_q, tot_new;
	logic             done;

	assign clearing   = clr_q;
	assign issue_last = busy_q && ((cur_q.kind != OP_DEP) || (corner_q == 3'd7));
	assign op.ready   = !clr_q && (pend_q < 2'd2) && (!busy_q || issue_last);
	assign pop        = op.valid && op.ready;

	always_comb begin
		logic [IDX_W:0] up_ext;
		for (int a = 0; a < 3; a++) begin
			up_ext = {1'b0, cur_q.lo[a]} + 1'b1;
			if (corner_q[a]) begin
				idx_c[a] = (up_ext == SIDE_X) ? '0 : up_ext[IDX_W-1:0];
				wgt_c[a] = {1'b0, cur_q.frac[a]};
			end else begin
				idx_c[a] = cur_q.lo[a];
				wgt_c[a] = W_ONE - {1'b0, cur_q.frac[a]};
			end
		end
		if (cur_q.kind == OP_READ) begin
			addr_c = AW'(cur_q.cell_idx);
		end else begin
			addr_c = AW'(32'(idx_c[0]) * SQ32 + 32'(idx_c[1]) * SIDE32 + 32'(idx_c[2]));
		end
		rd_ok_c = (cur_q.kind == OP_DEP)
			|| ((cur_q.kind == OP_READ) && (32'(cur_q.cell_idx) < NCELLS32));
		wxy_c = 33'({16'b0, wgt_c[0]} * {16'b0, wgt_c[1]});
	end

	assign prod_w = 50'(wxy_s1) * 50'(wz_s1);
	assign prod_m = 65'(mass_s2) * 65'(w_s2);

	// read issued from stage two, data lands with stage three
	assign re  = v_s2 && rd_ok_s2;
	assign cur = (fwd_vld_q && (fwd_addr_q == addr_s3)) ? fwd_data_q : rdata;

	assign sum_cell = {1'b0, cur} + {1'b0, add_s3};
	assign cell_new = sum_cell[ACC_W] ? ACC_MAX : sum_cell[ACC_W-1:0];
	assign sum_tot  = {1'b0, mass_sum_q} + (ACC_W + 1)'(mass_s3);
	assign tot_new  = sum_tot[ACC_W] ? ACC_MAX : sum_tot[ACC_W-1:0];

	assign we    = clr_q || (v_s3 && (kind_s3 == OP_DEP));
	assign waddr = clr_q ? clr_cnt_q : addr_s3;
	assign wdata = clr_q ? '0 : cell_new;

	assign done      = v_s3 && last_s3;
	assign res.valid = done;

	always_comb begin
		case (kind_s3)
			OP_SKIP: res.data.status = ST_SKIP;
			OP_OOB:  res.data.status = ST_OOB;
			default: res.data.status = ST_OK;
		endcase
		res.data.cell_mass  = ((kind_s3 == OP_READ) && rd_ok_s3) ? cur : '0;
		res.data.total_mass = (kind_s3 == OP_DEP) ? tot_new : mass_sum_q;
	end

	cic_ram #(
		.WIDTH(ACC_W),
		.DEPTH(NCELLS)
	) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (addr_s2),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			corner_q   <= '0;
			pend_q     <= '0;
			clr_q      <= 1'b1;
			clr_cnt_q  <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			fwd_vld_q  <= 1'b0;
			mass_sum_q <= '0;
		end else begin
			if (pop) begin
				busy_q   <= 1'b1;
				corner_q <= '0;
			end else if (issue_last) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				corner_q <= corner_q + 3'd1;
			end
			if (pop && !res_taken) begin
				pend_q <= pend_q + 2'd1;
			end else if (res_taken && !pop) begin
				pend_q <= pend_q - 2'd1;
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(NCELLS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (we) begin
				fwd_vld_q <= 1'b1;
			end
			if (done && (kind_s3 == OP_DEP)) begin
				mass_sum_q <= tot_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= op.data;
		end
		last_s1  <= issue_last;
		kind_s1  <= cur_q.kind;
		addr_s1  <= addr_c;
		rd_ok_s1 <= rd_ok_c;
		mass_s1  <= cur_q.mass;
		wxy_s1   <= wxy_c;
		wz_s1    <= wgt_c[2];

		last_s2  <= last_s1;
		kind_s2  <= kind_s1;
		addr_s2  <= addr_s1;
		rd_ok_s2 <= rd_ok_s1;
		mass_s2  <= mass_s1;
		w_s2     <= prod_w[48:16];

		last_s3  <= last_s2;
		kind_s3  <= kind_s2;
		addr_s3  <= addr_s2;
		rd_ok_s3 <= rd_ok_s2;
		mass_s3  <= mass_s2;
		add_s3   <= prod_m[63:16];

		if (we) begin
			fwd_addr_q <= waddr;
			fwd_data_q <= wdata;
		end
	end
endmodule
